// ===== rtl/bmm_pkg.sv =====
// Shared types and constants for the bounded min/max table.
package bmm_pkg;

  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 5;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 2'd0,
    OP_MAX        = 2'd1,
    OP_REMOVE_MIN = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLOSE,
    S_EMIT
  } fsm_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } entry_t;

  typedef struct packed {
    logic write;
    logic step;
  } cell_ctl_t;

endpackage

// ===== rtl/bmm_if.sv =====
// Request, result and configuration channel interfaces.
interface bmm_req_if;
  import bmm_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [HANDLE_W-1:0] item_handle;
  logic [KEY_W-1:0]    item_key;
  modport source (output valid, output op, output item_handle, output item_key, input ready);
  modport sink (input valid, input op, input item_handle, input item_key, output ready);
endinterface

interface bmm_rsp_if;
  import bmm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [KEY_W-1:0]    out_key;
  logic [COUNT_W-1:0]  entry_count;
  modport source (output valid, output status, output out_handle, output out_key,
                  output entry_count, input ready);
  modport sink (input valid, input status, input out_handle, input out_key,
                input entry_count, output ready);
endinterface

interface bmm_cfg_if;
  import bmm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;
  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

// ===== rtl/bmm_cell.sv =====
// One table cell: holds an entry, loads a new one or takes its neighbor's.
module bmm_cell (
  input  logic               clk,
  input  bmm_pkg::cell_ctl_t ctl,
  input  bmm_pkg::entry_t    wr,
  input  bmm_pkg::entry_t    nbr,
  output bmm_pkg::entry_t    q
);
  import bmm_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      q <= wr;
    end else if (ctl.step) begin
      q <= nbr;
    end
  end

endmodule

// ===== rtl/bmm_scan.sv =====
// Running best tracker that watches the head of the rotating cell row.
module bmm_scan #(
  parameter int IW        = 4,
  parameter int MIN_START = 9999
) (
  input  logic            clk,
  input  logic            start,
  input  logic            start_max,
  input  logic            step,
  input  logic            live,
  input  logic [IW-1:0]   idx,
  input  bmm_pkg::entry_t head,
  output logic [IW-1:0]   sel_idx,
  output bmm_pkg::entry_t sel_entry
);
  import bmm_pkg::*;

  logic             is_max;
  logic [KEY_W-1:0] best;
  logic             beats;

  assign beats = is_max ? (head.key > best) : (head.key < best);

  always_ff @(posedge clk) begin
    if (start) begin
      is_max <= start_max;
      best   <= start_max ? '0 : KEY_W'(MIN_START);
    end else if (step && live) begin
      if (beats) begin
        best      <= head.key;
        sel_idx   <= idx;
        sel_entry <= head;
      end else if (idx == '0) begin
        // Entry 0 is the fallback when no key beats the starting value.
        sel_idx   <= '0;
        sel_entry <= head;
      end
    end
  end

endmodule

// ===== rtl/bounded_minmax_table.sv =====
// Bounded min/max table built as a ring of entry cells with a scan tracker.
// Add, the unused op and max or remove_min on an empty table go from idle straight to emit.
// Max and remove_min scan while the cell ring rotates once through the head cell, one entry
// per cycle, and remove_min then passes through a close state that shuts the gap. One request
// is in work at a time, so a new request is taken only once the table is back in idle;
// a finished result may wait, and the next one then stalls until taken.
// Synchronous reset empties the table and sets capacity to 16.
module bounded_minmax_table #(
  parameter int DEPTH     = 16,
  parameter int MIN_START = 9999
) (
  input  logic           clk,
  input  logic           rst,
  bmm_cfg_if.sink        cfg,
  bmm_req_if.sink        req,
  bmm_rsp_if.source      rsp
);
  import bmm_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  fsm_t              state, state_next;
  logic [IW-1:0]     t;
  logic [CW-1:0]     fill;
  logic [CAP_W-1:0]  capacity;
  logic              is_min;
  logic              res_scan;
  status_t           res_status;

  logic [MW-1:0]     eff_cap;
  logic              full;
  logic              accept;
  logic              scan_start;
  logic              live;
  logic [IW-1:0]     sel_idx;
  entry_t            sel_entry;
  entry_t            wr_entry;
  entry_t            cells [DEPTH];

  assign accept  = req.valid && req.ready;
  assign eff_cap = (MW'(capacity) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(capacity);
  assign full    = MW'(fill) >= eff_cap;
  assign live    = CW'(t) < fill;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign wr_entry  = '{handle: req.item_handle, key: req.item_key};
  assign scan_start = accept && (req.op == OP_MAX || req.op == OP_REMOVE_MIN) && (fill != '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.write = accept && (req.op == OP_ADD) && !full && (fill == CW'(i));
    if (i < DEPTH - 1) begin : g_close
      assign ctl.step = (state == S_SCAN) || ((state == S_CLOSE) && (IW'(i) >= sel_idx));
    end else begin : g_last
      assign ctl.step = (state == S_SCAN);
    end
    bmm_cell u_cell (
      .clk (clk),
      .ctl (ctl),
      .wr  (wr_entry),
      .nbr (cells[(i + 1) % DEPTH]),
      .q   (cells[i])
    );
  end

  bmm_scan #(
    .IW        (IW),
    .MIN_START (MIN_START)
  ) u_scan (
    .clk       (clk),
    .start     (scan_start),
    .start_max (req.op == OP_MAX),
    .step      (state == S_SCAN),
    .live      (live),
    .idx       (t),
    .head      (cells[0]),
    .sel_idx   (sel_idx),
    .sel_entry (sel_entry)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (scan_start) begin
          state_next = S_SCAN;
        end else if (accept) begin
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        if (t == IW'(DEPTH - 1)) begin
          state_next = is_min ? S_CLOSE : S_EMIT;
        end
      end
      S_CLOSE: state_next = S_EMIT;
      S_EMIT: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      capacity <= CAP_W'(16);
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.capacity;
      end
      if (accept && req.op == OP_ADD && !full) begin
        fill <= fill + 1'b1;
      end else if (state == S_CLOSE) begin
        fill <= fill - 1'b1;
      end
      if (state == S_EMIT && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t        <= '0;
      is_min   <= (req.op == OP_REMOVE_MIN);
      res_scan <= scan_start;
      case (req.op)
        OP_ADD:                 res_status <= full ? ST_FULL : ST_OK;
        OP_MAX, OP_REMOVE_MIN:  res_status <= (fill == '0) ? ST_EMPTY : ST_OK;
        default:                res_status <= ST_OK;
      endcase
    end else if (state == S_SCAN) begin
      t <= t + 1'b1;
    end
    if (state == S_EMIT && (!rsp.valid || rsp.ready)) begin
      rsp.status      <= res_status;
      rsp.out_handle  <= res_scan ? sel_entry.handle : '0;
      rsp.out_key     <= res_scan ? sel_entry.key : '0;
      rsp.entry_count <= COUNT_W'(fill);
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count exceeds table depth");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_ADD && !full) |=> (fill == $past(fill) + 1'b1))
    else $error("accepted add did not grow the table");

  a_close_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLOSE) |-> (fill != '0))
    else $error("gap close on an empty table");

  a_emit_after_scan: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_SCAN && state == S_EMIT) |-> !is_min)
    else $error("remove_min skipped the gap close");
`endif

endmodule
